@@ hw/rtl/hoc_pkg.sv @@
`default_nettype none
package hoc_pkg;

  localparam int COUNT_W = 32;
  localparam int CUT_W   = 7;
  localparam logic [CUT_W-1:0] CUT_NONE = 7'h7F;

  typedef enum logic [3:0] {
    ST_LOAD, ST_START, ST_READ, ST_ACCUM, ST_MSTART, ST_MWAIT,
    ST_DIFF, ST_CHECK, ST_CMP, ST_NEXT, ST_OUT
  } state_t;

  // multiplier jobs: MT*W, M*N, d*d, W*(N-W), num*best_den, best_num*den
  typedef enum logic [2:0] {
    OP_AW, OP_BN, OP_DD, OP_DEN, OP_LR, OP_RR
  } mul_op_t;

  typedef enum logic [1:0] {
    RES_NEG1, RES_ZERO, RES_BEST
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     init;
    logic     rd;
    logic     acc;
    logic     mul_start;
    logic     cap;
    logic     diff;
    logic     take;
    logic     next;
    logic     out_load;
    mul_op_t  op;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic more;
    logic k_zero;
    logic den_zero;
    logic gt;
    logic mul_done;
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/hoc_if.sv @@
`default_nettype none
interface hoc_in_if;
  logic                        valid;
  logic                        ready;
  logic [hoc_pkg::COUNT_W-1:0] bin_count;
  logic                        last_bin;
  modport source (output valid, bin_count, last_bin, input ready);
  modport sink (input valid, bin_count, last_bin, output ready);
endinterface

interface hoc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [hoc_pkg::CUT_W-1:0] cutoff_bin;
  modport source (output valid, cutoff_bin, input ready);
  modport sink (input valid, cutoff_bin, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hoc_mul.sv @@
`default_nettype none
// Multi-limb multiplier: one 32x32 partial product per cycle, column by column.
module hoc_mul #(
  parameter int LIMBS = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [32*LIMBS-1:0]   a,
  input  wire logic [32*LIMBS-1:0]   b,
  output logic                       done,
  output logic [64*LIMBS-1:0]        prod
);
  localparam int CIW  = $clog2(2 * LIMBS);
  localparam int IIW  = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int ACCW = 64 + IIW + 2;

  logic              busy_r, pv_r, plast_r, pfin_r, done_r;
  logic [CIW-1:0]    col_r;
  logic [IIW-1:0]    i_r;
  logic [63:0]       p_r;
  logic [ACCW-1:0]   acc_r, sum;
  logic [64*LIMBS-1:0] res_r;
  logic [CIW-1:0]    jx;
  logic              in_rng, last_i;
  logic [31:0]       al, bl;

  assign jx     = col_r - CIW'(i_r);
  assign in_rng = (col_r >= CIW'(i_r)) && (jx < CIW'(LIMBS));
  assign last_i = (i_r == IIW'(LIMBS - 1));
  assign al     = a[i_r*32 +: 32];
  assign bl     = in_rng ? b[jx[IIW-1:0]*32 +: 32] : 32'd0;
  assign sum    = acc_r + ACCW'(p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pv_r   <= busy_r;
      done_r <= pv_r && pfin_r;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_i && col_r == CIW'(2 * LIMBS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      col_r <= '0;
      i_r   <= '0;
      acc_r <= '0;
    end else begin
      if (busy_r) begin
        p_r     <= in_rng ? al * bl : 64'd0;
        plast_r <= last_i;
        pfin_r  <= last_i && col_r == CIW'(2 * LIMBS - 1);
        if (last_i) begin
          i_r   <= '0;
          col_r <= col_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      if (pv_r) begin
        if (plast_r) begin
          res_r <= {sum[31:0], res_r[64*LIMBS-1:32]};
          acc_r <= sum >> 32;
        end else begin
          acc_r <= sum;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = res_r;
endmodule
`default_nettype wire

@@ hw/rtl/hoc_dp.sv @@
`default_nettype none
module hoc_dp #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire hoc_pkg::cmd_t               cmd,
  input  wire logic [hoc_pkg::COUNT_W-1:0] bin_count,
  output hoc_pkg::stat_t                   stat,
  output logic [hoc_pkg::CUT_W-1:0]        cutoff
);
  localparam int AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNTW = $clog2(MAX_BINS + 1);
  localparam int SW   = CNTW + 1;
  localparam int CBE  = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam int NW   = CBE + AW;
  localparam int MW   = CBE + 2 * AW;
  localparam int DW   = NW + MW;
  localparam int NUMW = 2 * DW;
  localparam int DENW = 2 * NW;
  localparam int XW   = NUMW + DENW;
  localparam int L    = (NUMW + 31) / 32;
  localparam int OPW  = 32 * L;
  localparam int PW   = 64 * L;
  localparam int CUT_W_L = hoc_pkg::CUT_W;

  logic [CBE-1:0]  mem [MAX_BINS];
  logic [CBE-1:0]  c, rd_r;
  logic [CNTW-1:0] n_r;
  logic [NW-1:0]   tot_n_r, w_r;
  logic [MW-1:0]   tot_m_r, m_r;
  logic [AW-1:0]   k_r, best_r;
  logic [DW-1:0]   a_r, b_r, d_r;
  logic [NUMW-1:0] num_r, bnum_r;
  logic [DENW-1:0] den_r, bden_r;
  logic [XW-1:0]   lhs_r, rhs_r;
  logic [CUT_W_L-1:0] cut_r;
  logic [AW+CBE-1:0] wload, wacc;
  logic [OPW-1:0]  opa, opb;
  logic [PW-1:0]   prod;
  logic            mdone;
  logic [AW+6:0]   best_ext;

  assign c     = bin_count[CBE-1:0];
  assign wload = n_r[AW-1:0] * c;
  assign wacc  = k_r * rd_r;

  always_comb begin
    case (cmd.op)
      hoc_pkg::OP_AW:  begin opa = OPW'(tot_m_r); opb = OPW'(w_r); end
      hoc_pkg::OP_BN:  begin opa = OPW'(m_r);     opb = OPW'(tot_n_r); end
      hoc_pkg::OP_DD:  begin opa = OPW'(d_r);     opb = OPW'(d_r); end
      hoc_pkg::OP_DEN: begin opa = OPW'(w_r);     opb = OPW'(tot_n_r - w_r); end
      hoc_pkg::OP_LR:  begin opa = OPW'(num_r);   opb = OPW'(bden_r); end
      hoc_pkg::OP_RR:  begin opa = OPW'(bnum_r);  opb = OPW'(den_r); end
      default:         begin opa = '0;            opb = '0; end
    endcase
  end

  hoc_mul #(.LIMBS(L)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mdone),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load && n_r < CNTW'(MAX_BINS)) begin
      mem[n_r[AW-1:0]] <= c;
    end
    if (cmd.rd) begin
      rd_r <= mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      tot_n_r <= '0;
      tot_m_r <= '0;
    end else if (cmd.clear) begin
      n_r     <= '0;
      tot_n_r <= '0;
      tot_m_r <= '0;
    end else if (cmd.load && n_r < CNTW'(MAX_BINS)) begin
      n_r     <= n_r + 1'b1;
      tot_n_r <= tot_n_r + NW'(c);
      tot_m_r <= tot_m_r + MW'(wload);
    end
  end

  assign best_ext = {7'd0, best_r};

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      k_r    <= '0;
      w_r    <= '0;
      m_r    <= '0;
      best_r <= '0;
    end
    if (cmd.acc) begin
      w_r <= w_r + NW'(rd_r);
      m_r <= m_r + MW'(wacc);
    end
    if (cmd.next) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.diff) begin
      d_r <= (a_r >= b_r) ? a_r - b_r : b_r - a_r;
    end
    if (cmd.take) begin
      bnum_r <= num_r;
      bden_r <= den_r;
      best_r <= k_r;
    end
    if (cmd.cap) begin
      case (cmd.op)
        hoc_pkg::OP_AW:  a_r   <= prod[DW-1:0];
        hoc_pkg::OP_BN:  b_r   <= prod[DW-1:0];
        hoc_pkg::OP_DD:  num_r <= prod[NUMW-1:0];
        hoc_pkg::OP_DEN: den_r <= prod[DENW-1:0];
        hoc_pkg::OP_LR:  lhs_r <= prod[XW-1:0];
        hoc_pkg::OP_RR:  rhs_r <= prod[XW-1:0];
        default:         ;
      endcase
    end
    if (cmd.out_load) begin
      case (cmd.res_sel)
        hoc_pkg::RES_NEG1: cut_r <= hoc_pkg::CUT_NONE;
        hoc_pkg::RES_ZERO: cut_r <= '0;
        hoc_pkg::RES_BEST: cut_r <= best_ext[6:0];
        default:           cut_r <= hoc_pkg::CUT_NONE;
      endcase
    end
  end

  assign stat.n_lt2    = n_r < CNTW'(2);
  assign stat.more     = (SW'(k_r) + SW'(2)) < SW'(n_r);
  assign stat.k_zero   = (k_r == '0);
  assign stat.den_zero = (den_r == '0);
  assign stat.gt       = lhs_r > rhs_r;
  assign stat.mul_done = mdone;
  assign cutoff        = cut_r;
endmodule
`default_nettype wire

@@ hw/rtl/hoc_ctrl.sv @@
`default_nettype none
module hoc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire hoc_pkg::stat_t stat,
  output hoc_pkg::cmd_t       cmd
);
  hoc_pkg::state_t   state_r, state_nxt;
  hoc_pkg::mul_op_t  op_r, op_nxt;
  hoc_pkg::res_sel_t sel_r, sel_nxt;
  logic              ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hoc_pkg::ST_LOAD;
      op_r    <= hoc_pkg::OP_AW;
      sel_r   <= hoc_pkg::RES_NEG1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      sel_r   <= sel_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    sel_nxt     = sel_r;
    ov_nxt      = ov_r && !out_ready;
    cmd         = '0;
    cmd.op      = op_r;
    cmd.res_sel = sel_r;
    in_ready    = 1'b0;
    case (state_r)
      hoc_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = hoc_pkg::ST_START;
        end
      end
      hoc_pkg::ST_START: begin
        if (stat.n_lt2) begin
          sel_nxt   = hoc_pkg::RES_NEG1;
          state_nxt = hoc_pkg::ST_OUT;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = hoc_pkg::ST_READ;
        end
      end
      hoc_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = hoc_pkg::ST_ACCUM;
      end
      hoc_pkg::ST_ACCUM: begin
        cmd.acc   = 1'b1;
        op_nxt    = hoc_pkg::OP_AW;
        state_nxt = hoc_pkg::ST_MSTART;
      end
      hoc_pkg::ST_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = hoc_pkg::ST_MWAIT;
      end
      hoc_pkg::ST_MWAIT: begin
        if (stat.mul_done) begin
          cmd.cap = 1'b1;
          case (op_r)
            hoc_pkg::OP_AW: begin
              op_nxt    = hoc_pkg::OP_BN;
              state_nxt = hoc_pkg::ST_MSTART;
            end
            hoc_pkg::OP_BN:  state_nxt = hoc_pkg::ST_DIFF;
            hoc_pkg::OP_DD: begin
              op_nxt    = hoc_pkg::OP_DEN;
              state_nxt = hoc_pkg::ST_MSTART;
            end
            hoc_pkg::OP_DEN: state_nxt = hoc_pkg::ST_CHECK;
            hoc_pkg::OP_LR: begin
              op_nxt    = hoc_pkg::OP_RR;
              state_nxt = hoc_pkg::ST_MSTART;
            end
            hoc_pkg::OP_RR:  state_nxt = hoc_pkg::ST_CMP;
            default:         state_nxt = hoc_pkg::ST_NEXT;
          endcase
        end
      end
      hoc_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        op_nxt    = hoc_pkg::OP_DD;
        state_nxt = hoc_pkg::ST_MSTART;
      end
      hoc_pkg::ST_CHECK: begin
        if (stat.k_zero) begin
          if (stat.den_zero) begin
            // degenerate first split pins the answer at bin 0
            sel_nxt   = hoc_pkg::RES_ZERO;
            state_nxt = hoc_pkg::ST_OUT;
          end else begin
            cmd.take  = 1'b1;
            state_nxt = hoc_pkg::ST_NEXT;
          end
        end else if (stat.den_zero) begin
          state_nxt = hoc_pkg::ST_NEXT;
        end else begin
          op_nxt    = hoc_pkg::OP_LR;
          state_nxt = hoc_pkg::ST_MSTART;
        end
      end
      hoc_pkg::ST_CMP: begin
        cmd.take  = stat.gt;
        state_nxt = hoc_pkg::ST_NEXT;
      end
      hoc_pkg::ST_NEXT: begin
        if (stat.more) begin
          cmd.next  = 1'b1;
          state_nxt = hoc_pkg::ST_READ;
        end else begin
          sel_nxt   = hoc_pkg::RES_BEST;
          state_nxt = hoc_pkg::ST_OUT;
        end
      end
      hoc_pkg::ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = hoc_pkg::ST_LOAD;
        end
      end
      default: state_nxt = hoc_pkg::ST_LOAD;
    endcase
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire

@@ hw/rtl/histogram_otsu_cutoff.sv @@
// Loading: one bin per cycle, ready is high in the load phase, also while a result waits.
// After the marked bin, each cut k reads its bin, adds it to W and M, then runs MT*W, M*N,
// d*d, W*(N-W) and, for later cuts, num*best_den and best_num*den on the single 32x32
// multiplier, L the 32-bit limbs of the 2*(2*COUNT_BITS+3*log2(MAX_BINS))-bit score
// (L=6 by default). Reset (rst_n low, synchronous) clears the controller, the output
// valid and the running sums; the bin memory holds no reset value, read only once written.
`default_nettype none
module histogram_otsu_cutoff #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hoc_in_if.sink    in_ch,
  hoc_out_if.source out_ch
);
  hoc_pkg::cmd_t               cmd;
  hoc_pkg::stat_t              stat;
  logic [hoc_pkg::CUT_W-1:0]   cut;

  // sequencer: load phase, then per-cut multiply/compare program
  hoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_bin),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // bin memory, running sums, score registers and the limb multiplier
  hoc_dp #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .bin_count (in_ch.bin_count),
    .stat      (stat),
    .cutoff    (cut)
  );

  assign out_ch.cutoff_bin = cut;
endmodule
`default_nettype wire

@@ hw/rtl/hoc_chk.sv @@
`default_nettype none
module hoc_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             in_last,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [hoc_pkg::CUT_W-1:0] cutoff_bin
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cutoff_bin))
    else $error("result dropped or changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> !$rose(out_valid))
    else $error("result raised by an unmarked bin");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken while the cut is being computed");
endmodule

bind histogram_otsu_cutoff hoc_chk u_hoc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_bin),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cutoff_bin (out_ch.cutoff_bin)
);
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  localparam int COUNT_W = hoc_pkg::COUNT_W;
  localparam int CUT_W   = hoc_pkg::CUT_W;
  localparam logic [CUT_W-1:0] CUT_NONE = hoc_pkg::CUT_NONE;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  hoc_in_if  in_if ();
  hoc_out_if out_if ();

  histogram_otsu_cutoff uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  localparam int NBINS = 64;

  // predictor's copy of the block state
  logic [COUNT_W-1:0] hist_bins [NBINS];
  int                 bins_held;
  logic signed [CUT_W-1:0] cut_q[$];   // expected cut bins, oldest first
  bit   failed;
  int   items_sent;
  int   burst_left;

  // Exact Otsu cut over the first n bins; lower k wins ties.
  // 256 bits covers the widest cross product (~2^240).
  function automatic logic signed [CUT_W-1:0] otsu_cut(input int n);
    logic [255:0] tot_n, tot_m, w, m, a, b, d, num, den, bnum, bden;
    int best;
    if (n < 2) return CUT_NONE;
    tot_n = '0;
    tot_m = '0;
    for (int i = 0; i < n; i++) begin
      tot_n += hist_bins[i];
      tot_m += 256'(i) * hist_bins[i];
    end
    w = '0;
    m = '0;
    best = 0;
    bnum = '0;
    bden = '0;
    for (int k = 0; k + 1 < n; k++) begin
      w += hist_bins[k];
      m += 256'(k) * hist_bins[k];
      a = tot_m * w;
      b = m * tot_n;
      d = (a >= b) ? a - b : b - a;
      num = d * d;
      den = w * (tot_n - w);
      if (k == 0) begin
        // invalid first score locks the answer at 0
        if (den == 0) return '0;
        bnum = num;
        bden = den;
      end else if (den != 0 && num * bden > bnum * den) begin
        bnum = num;
        bden = den;
        best = k;
      end
    end
    return CUT_W'(best);
  endfunction

  // Sender: bursts of random length with random gaps. Expectation is queued
  // before the marked transfer completes; the result always comes later.
  task automatic send_bin(input logic [COUNT_W-1:0] cnt, input bit last,
                          input bit typed, input logic signed [CUT_W-1:0] typed_cut);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
    end
    burst_left--;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (bins_held < NBINS) begin
      hist_bins[bins_held] = cnt;
      bins_held++;
    end
    if (last) begin
      cut_q = {cut_q, (typed ? typed_cut : otsu_cut(bins_held))};
      bins_held = 0;
    end
    in_if.valid     <= 1'b1;
    in_if.bin_count <= cnt;
    in_if.last_bin  <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Receiver stall pattern: phases of always-ready, coin flip, mostly stalled, periodic.
  int unsigned cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (cyc[10:9])
      2'd0: out_if.ready <= 1'b1;
      2'd1: out_if.ready <= $urandom_range(0, 1);
      2'd2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= (cyc[3:0] < 4'd5);
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (cut_q.size() == 0) begin
        $error("cutoff_bin: no result expected, got %0d", out_if.cutoff_bin);
        failed = 1'b1;
      end else begin
        if (out_if.cutoff_bin !== cut_q[0]) begin
          $error("cutoff_bin: expected %0d, got %0d", cut_q[0], out_if.cutoff_bin);
          failed = 1'b1;
        end
        void'(cut_q.pop_front());
      end
    end
  end

  // Directed rows: count, marked, expected typed in, expected cut
  typedef struct {
    logic [COUNT_W-1:0]      cnt;
    bit                      last;
    bit                      typed;
    logic signed [CUT_W-1:0] cut;
  } dir_row_t;

  localparam logic [COUNT_W-1:0] CMAX = '1;

  dir_row_t dir_rows[] = '{
    '{32'd5, 1, 1, CUT_NONE},                          // single bin
    '{32'd0, 0, 0, 0}, '{32'd0, 0, 0, 0},
    '{32'd0, 1, 1, 7'sd0},                             // empty histogram
    '{32'd7, 0, 0, 0}, '{32'd0, 0, 0, 0},
    '{32'd0, 1, 1, 7'sd0},                             // W=N at first cut
    '{32'd0, 0, 0, 0}, '{32'd3, 0, 0, 0},
    '{32'd4, 1, 1, 7'sd0},                             // W=0 at first cut
    '{CMAX, 0, 0, 0}, '{CMAX, 1, 1, 7'sd0},            // largest counts, one cut
    '{32'd1, 0, 0, 0}, '{32'd0, 0, 0, 0}, '{32'd0, 0, 0, 0},
    '{32'd5, 1, 0, 0},                                 // equal scores at later cuts
    '{32'd10, 0, 0, 0}, '{32'd0, 0, 0, 0}, '{32'd0, 0, 0, 0},
    '{32'd10, 1, 0, 0},                                // tie between cuts
    '{CMAX, 0, 0, 0}, '{32'd1, 0, 0, 0}, '{32'h5555_AAAA, 0, 0, 0},
    '{CMAX, 1, 0, 0}
  };

  function automatic logic [COUNT_W-1:0] rand_count(input int style);
    case (style)
      0: return $urandom();
      1: return $urandom_range(0, 15);
      2: return ($urandom_range(0, 2) == 0) ? '0 : $urandom_range(0, 1000);
      default: return ($urandom_range(0, 1) == 0) ? CMAX - $urandom_range(0, 7) :
                                                    $urandom_range(0, 3);
    endcase
  endfunction

  initial begin
    int nb, style, pick;
    in_if.valid     <= 1'b0;
    in_if.bin_count <= '0;
    in_if.last_bin  <= 1'b0;
    failed     = 1'b0;
    bins_held  = 0;
    items_sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_bin(dir_rows[i].cnt, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].cut);

    // Random histograms: mostly short ones, a few full and overfull ones.
    while (items_sent < 1900) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       nb = 1;
      else if (pick < 85) nb = $urandom_range(2, 4);
      else if (pick < 98) nb = $urandom_range(5, 12);
      else                nb = $urandom_range(63, 66);   // edge of capacity and past it
      style = $urandom_range(0, 3);
      for (int i = 0; i < nb; i++)
        send_bin(rand_count(style), i == nb - 1, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (cut_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
